@@ sv/memory_byte_pattern_search_unit_defines.svh @@
// Assertion macros shared by the pattern search RTL.
`ifndef MEMORY_BYTE_PATTERN_SEARCH_UNIT_DEFINES_SVH
`define MEMORY_BYTE_PATTERN_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBPS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pattern search assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MBPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pattern search assertion failed");

`endif

@@ sv/mbps_pkg.sv @@
// Shared types and constants of the memory byte pattern search unit.
`default_nettype none

package mbps_pkg;

    localparam int MAX_PATTERN  = 16;
    localparam int MEMORY_BANKS = 128;

    localparam int BANK_BYTES = 8192;
    localparam int ADDR_W     = 20;
    localparam int ADDR_SPACE = 1 << ADDR_W;
    localparam int BANK_SPAN  = MEMORY_BANKS * BANK_BYTES;
    localparam int MEM_SIZE   = (BANK_SPAN > ADDR_SPACE) ? ADDR_SPACE : BANK_SPAN;

    localparam int PAT_BYTES = 16;
    localparam int LEN_W     = 5;
    localparam int WIN_SLOTS = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
    localparam int SEEN_W    = $clog2(MAX_PATTERN + 1);
    localparam int HAVE_W    = SEEN_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_PATTERN_LENGTH = 3'd2,
        CFG_START_ADDRESS  = 3'd3,
        CFG_RESUME_SEARCH  = 3'd4
    } cfg_index_t;

    typedef enum logic {
        CMD_BEGIN = 1'b0,
        CMD_BYTE  = 1'b1
    } command_t;

    typedef logic [PAT_BYTES-1:0][7:0] pattern_t;
    typedef logic [WIN_SLOTS-1:0][7:0] window_t;

    // Control handed to the comparator for one incoming byte.
    typedef struct packed {
        pattern_t         pattern;
        logic [LEN_W-1:0] used_len;
        logic             enough;
    } match_ctrl_t;

endpackage

`default_nettype wire

@@ sv/mbps_match.sv @@
// Parallel comparison of the byte window against the active pattern.
`default_nettype none

module mbps_match
    import mbps_pkg::*;
(
    input  wire logic        [7:0] cur_byte,
    input  wire window_t           window,
    input  wire match_ctrl_t       ctrl,
    output logic                   hit
);

    logic [MAX_PATTERN-1:0][7:0] recent;
    logic [MAX_PATTERN-1:0]      pos_ok;
    logic [LEN_W-1:0]            pat_idx [MAX_PATTERN];

    // Newest byte first: position k holds the byte k places back.
    always_comb begin
        recent[0] = cur_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            recent[k] = window[k-1];
        end
    end

    // Position k must equal pattern byte len-1-k; unused positions pass.
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pat_idx[k] = ctrl.used_len - LEN_W'(k) - LEN_W'(1);
            if (LEN_W'(k) < ctrl.used_len) begin
                pos_ok[k] = (recent[k] == ctrl.pattern[pat_idx[k][3:0]]);
            end else begin
                pos_ok[k] = 1'b1;
            end
        end
    end

    assign hit = ctrl.enough && (&pos_ok);

endmodule

`default_nettype wire

@@ sv/memory_byte_pattern_search_unit.sv @@
// Top level of the memory byte pattern search unit.
// A result word appears on the master side in the cycle after the input word that causes it.
// Throughput: one input word per cycle; the comparator over the byte window is a single pass.
// Only a stalled result holds off the slave side, and only while it waits.
// Reset (aresetn low, synchronous) clears the registers, window, address, search state and result.
`default_nettype none
`include "memory_byte_pattern_search_unit_defines.svh"

module memory_byte_pattern_search_unit
    import mbps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    // Input words.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] data_byte
    input  wire logic                  s_tuser,   // [0] command

    // Result words.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,   // [19:0] location, [23:20] zero
    output logic                       m_tuser    // [0] found
);

    // ------------------------------------------------------------------
    // Configuration registers. The port never pushes back; writes must arrive
    // only while the block is quiet, a rule on the user that the block does not enforce.
    // ------------------------------------------------------------------
    pattern_t           pattern_reg;
    logic [LEN_W-1:0]   pattern_length_reg;
    logic [ADDR_W-1:0]  start_address_reg;
    logic               resume_search_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg        <= '0;
            pattern_length_reg <= '0;
            start_address_reg  <= '0;
            resume_search_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:    pattern_reg[7:0]  <= cfg_data;
                CFG_PATTERN_HIGH:   pattern_reg[15:8] <= cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                CFG_START_ADDRESS:  start_address_reg  <= cfg_data[ADDR_W-1:0];
                CFG_RESUME_SEARCH:  resume_search_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Search state. The window holds the most recent bytes, newest in
    // slot zero; the byte being taken is compared alongside it.
    // ------------------------------------------------------------------
    window_t            window_reg,        window_next;
    logic [ADDR_W-1:0]  next_address_reg,  next_address_next;
    logic [SEEN_W-1:0]  bytes_seen_reg,    bytes_seen_next;
    logic               active_reg,        active_next;

    // Result register, which parts the two sides of the block.
    logic               m_valid_reg,       m_valid_next;
    logic               found_reg,         found_next;
    logic [ADDR_W-1:0]  location_reg,      location_next;

    logic               s_hs;
    logic [ADDR_W:0]    first_addr;
    logic [ADDR_W:0]    following_addr;
    logic [LEN_W-1:0]   used_len;
    logic [HAVE_W-1:0]  have;
    match_ctrl_t        match_ctrl;
    logic               hit;

    // A new word is taken whenever the result slot is empty or emptying.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_hs     = s_tvalid && s_tready;

    // Lengths above the window reach saturate at the largest pattern.
    assign used_len = (pattern_length_reg > LEN_W'(MAX_PATTERN))
                      ? LEN_W'(MAX_PATTERN) : pattern_length_reg;
    assign have     = HAVE_W'(bytes_seen_reg) + HAVE_W'(1);

    assign first_addr     = {1'b0, start_address_reg} + (ADDR_W+1)'(resume_search_reg);
    assign following_addr = {1'b0, next_address_reg} + (ADDR_W+1)'(1);

    assign match_ctrl.pattern  = pattern_reg;
    assign match_ctrl.used_len = used_len;
    assign match_ctrl.enough   = (used_len != '0) && (have >= HAVE_W'(used_len));

    mbps_match u_match (
        .cur_byte (s_tdata),
        .window   (window_reg),
        .ctrl     (match_ctrl),
        .hit      (hit)
    );

    always_comb begin
        window_next       = window_reg;
        next_address_next = next_address_reg;
        bytes_seen_next   = bytes_seen_reg;
        active_next       = active_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        found_next        = found_reg;
        location_next     = location_reg;

        if (s_hs) begin
            unique case (command_t'(s_tuser))
                CMD_BEGIN: begin
                    // A begin always restarts with an empty window.
                    window_next     = '0;
                    bytes_seen_next = '0;
                    if ((pattern_length_reg == '0) ||
                        (first_addr >= (ADDR_W+1)'(MEM_SIZE))) begin
                        active_next   = 1'b0;
                        m_valid_next  = 1'b1;
                        found_next    = 1'b0;
                        location_next = '0;
                    end else begin
                        active_next       = 1'b1;
                        next_address_next = first_addr[ADDR_W-1:0];
                    end
                end
                CMD_BYTE: begin
                    // Bytes that arrive while no search runs are dropped.
                    if (active_reg) begin
                        window_next[0] = s_tdata;
                        for (int j = 1; j < WIN_SLOTS; j++) begin
                            window_next[j] = window_reg[j-1];
                        end
                        bytes_seen_next = (have > HAVE_W'(MAX_PATTERN))
                                          ? SEEN_W'(MAX_PATTERN) : have[SEEN_W-1:0];
                        if (hit) begin
                            // The match began len-1 bytes before this one.
                            active_next   = 1'b0;
                            m_valid_next  = 1'b1;
                            found_next    = 1'b1;
                            location_next = next_address_reg - ADDR_W'(used_len)
                                            + ADDR_W'(1);
                        end else if (following_addr >= (ADDR_W+1)'(MEM_SIZE)) begin
                            // The top byte of memory completed no match.
                            active_next   = 1'b0;
                            m_valid_next  = 1'b1;
                            found_next    = 1'b0;
                            location_next = '0;
                        end else begin
                            next_address_next = following_addr[ADDR_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // The result payload resets with the rest, so the master side shows a
    // not-found word with a zero location until the first result arrives.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg       <= '0;
            next_address_reg <= '0;
            bytes_seen_reg   <= '0;
            active_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
            found_reg        <= 1'b0;
            location_reg     <= '0;
        end else begin
            window_reg       <= window_next;
            next_address_reg <= next_address_next;
            bytes_seen_reg   <= bytes_seen_next;
            active_reg       <= active_next;
            m_valid_reg      <= m_valid_next;
            found_reg        <= found_next;
            location_reg     <= location_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = {4'b0000, location_reg};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A not-found result always carries a zero location.
    `MBPS_ASSERT_NOW(a_notfound_zero, aclk, aresetn, m_valid_reg && !found_reg,
                     location_reg == '0)
    // Every result ends the search that produced it.
    `MBPS_ASSERT_NOW(a_result_idle, aclk, aresetn, m_valid_reg, !active_reg)
    // No result appears unless a word was taken.
    `MBPS_ASSERT_NEXT(a_no_phantom, aclk, aresetn, !s_hs && (m_tready || !m_valid_reg),
                      !m_valid_reg)
    // The fill count never passes the longest pattern.
    `MBPS_ASSERT_NOW(a_seen_bound, aclk, aresetn, 1'b1,
                     bytes_seen_reg <= SEEN_W'(MAX_PATTERN))

endmodule

`default_nettype wire
